// ===== sv/mse_pkg.sv =====
// mse_pkg: shared sizes and types for the merge sort engine
// no dependencies; imported by merge_sort_engine_unit
package mse_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int DATA_W       = 32;
   localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W        = ADDR_W + 1;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         cnt_type;

endpackage

// ===== sv/mse_ram.sv =====
// mse_ram: generic single write port, single read port ram with registered read
// no dependencies
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/merge_sort_engine_unit.sv =====
// merge_sort_engine_unit: block sorter top level, bottom-up merge sort
// depends on mse_pkg and mse_ram (two ping-pong element buffers)
//
// Usage:
//   req channel: one signed 32-bit element per beat; req_is_final ends the block.
//   Up to MAX_ELEMENTS elements are kept; later elements of the block are dropped
//   and every result of that block carries rsp_overflowed.
//   rsp channel: the kept elements in ascending order, one per beat, with
//   rsp_end_of_block on the last (greatest) one.
// Sequence:
//   loading accepts one beat per cycle (req_ready is high while loading).
//   After the final beat the sort runs ceil(log2(n)) passes; each pass is paced
//   by the single read port of the source buffer (at most one head refill per
//   element). Each result is then read from the buffer and loaded into the
//   output register before the next read is issued.
// Reset: synchronous, clears the element count, overflow mark and control;
//   buffer contents are not cleared (only entries of the current block are read).
// Stalls: the output register holds a result until rsp_ready; the next read is
//   issued only when the register is free. The last result may wait in the
//   register while the next block is already loading.
module merge_sort_engine_unit
   import mse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_value,
   input  logic        req_is_final,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_sorted_value,
   output logic        rsp_end_of_block,
   output logic        rsp_overflowed
);

   localparam logic [3:0] ST_LOAD   = 4'd0;
   localparam logic [3:0] ST_PASS   = 4'd1;
   localparam logic [3:0] ST_SEG    = 4'd2;
   localparam logic [3:0] ST_FILL_L = 4'd3;
   localparam logic [3:0] ST_FILL_R = 4'd4;
   localparam logic [3:0] ST_CMP    = 4'd5;
   localparam logic [3:0] ST_WAIT_L = 4'd6;
   localparam logic [3:0] ST_WAIT_R = 4'd7;
   localparam logic [3:0] ST_NEXT   = 4'd8;
   localparam logic [3:0] ST_OUT_RD = 4'd9;
   localparam logic [3:0] ST_OUT_LD = 4'd10;

   logic [3:0] state_ff, state_in;
   cnt_type    count_ff, count_in;
   logic       ovf_ff, ovf_in;
   logic       src_ff, src_in;
   cnt_type    width_ff, width_in;
   cnt_type    lo_ff, lo_in;
   cnt_type    mid_ff, mid_in;
   cnt_type    hi_ff, hi_in;
   cnt_type    i_ff, i_in;
   cnt_type    j_ff, j_in;
   cnt_type    k_ff, k_in;
   data_type   head_l_ff, head_l_in;
   data_type   head_r_ff, head_r_in;
   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_value_ff, rsp_value_in;
   logic       rsp_end_ff, rsp_end_in;
   logic       rsp_ovf_ff, rsp_ovf_in;

   // buffer ports
   logic       wr_a, wr_b;
   addr_type   wr_addr;
   data_type   wr_data;
   addr_type   rd_addr;
   logic [DATA_W-1:0] rd_data_a, rd_data_b;
   data_type   rd_data;

   logic       req_beat;
   logic       take_left;
   cnt_type    lo_w, lo_2w, k_next, i_next, j_next;

   mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_buf_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_a)
   );

   mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_buf_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data_b)
   );

   // read data comes from the current source buffer
   assign rd_data = src_ff ? data_type'(rd_data_b) : data_type'(rd_data_a);

   assign req_ready = (state_ff == ST_LOAD);
   assign req_beat  = req_valid && req_ready;

   // segment bounds and merge step arithmetic
   assign lo_w   = lo_ff + width_ff;
   assign lo_2w  = lo_ff + {width_ff[CNT_W-2:0], 1'b0};
   assign k_next = k_ff + cnt_type'(1);
   assign i_next = i_ff + cnt_type'(1);
   assign j_next = j_ff + cnt_type'(1);
   assign take_left = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (head_l_ff <= head_r_ff));

   // sequencer: load, merge passes, drain
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      src_in       = src_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      head_l_in    = head_l_ff;
      head_r_in    = head_r_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_a         = 1'b0;
      wr_b         = 1'b0;
      wr_addr      = k_ff[ADDR_W-1:0];
      wr_data      = take_left ? head_l_ff : head_r_ff;
      rd_addr      = lo_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_LOAD: begin
            wr_addr = count_ff[ADDR_W-1:0];
            wr_data = req_value;
            if (req_beat) begin
               if (count_ff < cnt_type'(MAX_ELEMENTS)) begin
                  wr_a     = 1'b1;
                  count_in = count_ff + cnt_type'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_is_final) begin
                  src_in   = 1'b0;
                  width_in = cnt_type'(1);
                  state_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            lo_in = '0;
            k_in  = '0;
            if (width_ff >= count_ff) begin
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            mid_in   = (lo_w < count_ff) ? lo_w : count_ff;
            hi_in    = (lo_2w < count_ff) ? lo_2w : count_ff;
            i_in     = lo_ff;
            j_in     = (lo_w < count_ff) ? lo_w : count_ff;
            k_in     = lo_ff;
            rd_addr  = lo_ff[ADDR_W-1:0];
            state_in = ST_FILL_L;
         end
         ST_FILL_L: begin
            head_l_in = rd_data;
            rd_addr   = mid_ff[ADDR_W-1:0];
            state_in  = (mid_ff < hi_ff) ? ST_FILL_R : ST_CMP;
         end
         ST_FILL_R: begin
            head_r_in = rd_data;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            wr_a = src_ff;
            wr_b = !src_ff;
            k_in = k_next;
            if (take_left) begin
               i_in    = i_next;
               rd_addr = i_next[ADDR_W-1:0];
            end else begin
               j_in    = j_next;
               rd_addr = j_next[ADDR_W-1:0];
            end
            priority if (k_next == hi_ff) begin
               lo_in    = lo_2w;
               state_in = ST_NEXT;
            end else if (take_left && (i_next < mid_ff)) begin
               state_in = ST_WAIT_L;
            end else if (!take_left && (j_next < hi_ff)) begin
               state_in = ST_WAIT_R;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_WAIT_L: begin
            head_l_in = rd_data;
            state_in  = ST_CMP;
         end
         ST_WAIT_R: begin
            head_r_in = rd_data;
            state_in  = ST_CMP;
         end
         ST_NEXT: begin
            if (lo_ff >= count_ff) begin
               width_in = {width_ff[CNT_W-2:0], 1'b0};
               src_in   = !src_ff;
               state_in = ST_PASS;
            end else begin
               state_in = ST_SEG;
            end
         end
         ST_OUT_RD: begin
            rd_addr = k_ff[ADDR_W-1:0];
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_OUT_LD;
            end
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data;
            rsp_ovf_in   = ovf_ff;
            rsp_end_in   = (k_next == count_ff);
            k_in         = k_next;
            if (k_next == count_ff) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         src_ff       <= 1'b0;
         width_ff     <= '0;
         lo_ff        <= '0;
         mid_ff       <= '0;
         hi_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         src_ff       <= src_in;
         width_ff     <= width_in;
         lo_ff        <= lo_in;
         mid_ff       <= mid_in;
         hi_ff        <= hi_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: merge heads and output beat
   always_ff @(posedge clock) begin
      head_l_ff    <= head_l_in;
      head_r_ff    <= head_r_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_block = rsp_end_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

endmodule
